// File: design/ivs_pkg.sv
// shared types, constants and helper functions of the ipa vowel stretcher
package ivs_pkg;

  localparam int IVS_FRACTION_BITS = 8;
  localparam int BYTE_W            = 8;
  localparam int CFG_W             = 10;
  localparam int LEN_W             = 3;
  localparam int CP_W              = 21;

  localparam logic [CFG_W-1:0] CFG_RESET = 10'd256;

  // control of the fractional accumulator
  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } acc_ctrl_t;

  // control of the code point fold unit
  typedef struct packed {
    logic load;
    logic step;
  } fold_ctrl_t;

  // character length fixed by a lead byte, 0 for a byte that cannot lead
  function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic vowel_point(input logic [CP_W-1:0] cp);
    logic v;
    case (cp)
      21'h61, 21'h41, 21'h65, 21'h45, 21'h69, 21'h49,
      21'h6F, 21'h4F, 21'h75, 21'h55, 21'h79, 21'h59,
      21'hE6, 21'hC6, 21'hF8, 21'hD8,
      21'h153, 21'h152,
      21'h250, 21'h251, 21'h252, 21'h254,
      21'h259, 21'h25A, 21'h25B, 21'h25C, 21'h25D, 21'h25E,
      21'h264, 21'h268, 21'h26A, 21'h26F,
      21'h275, 21'h276,
      21'h289, 21'h28A, 21'h28C, 21'h28F: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

// File: design/ivs_cp_fold.sv
// code point decoder: folds one byte of a character per cycle
module ivs_cp_fold
  import ivs_pkg::*;
(
  input  logic              clk_i,
  input  fold_ctrl_t        ctrl_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [LEN_W-1:0]  len_i,
  output logic              vowel_o
);

  logic [CP_W-1:0] cp_q, cp_d;

  always_comb begin
    cp_d = cp_q;
    if (ctrl_i.load) begin
      case (len_i)
        3'd1:    cp_d = CP_W'(byte_i);
        3'd2:    cp_d = CP_W'(byte_i[4:0]);
        3'd3:    cp_d = CP_W'(byte_i[3:0]);
        default: cp_d = CP_W'(byte_i[2:0]);
      endcase
    end else if (ctrl_i.step) begin
      // continuation bytes are taken as they come, top bits ignored
      cp_d = {cp_q[CP_W-7:0], byte_i[5:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q <= cp_d;
  end

  assign vowel_o = vowel_point(cp_q);

endmodule

// File: design/ivs_frac_acc.sv
// fractional vowel accumulator: one add, compare or subtract per cycle
module ivs_frac_acc
  import ivs_pkg::*;
#(
  parameter int FRACTION_BITS = IVS_FRACTION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acc_ctrl_t        ctrl_i,
  input  logic [CFG_W-1:0] factor_i,
  output logic             ge_unit_o
);

  localparam int AW = FRACTION_BITS + 2;
  localparam int FW = (AW > CFG_W) ? AW : CFG_W;
  localparam logic [FW-1:0] UNIT_F = FW'(1) << FRACTION_BITS;
  localparam logic [FW-1:0] TOP_F  = FW'(3) << FRACTION_BITS;
  localparam logic [AW-1:0] UNIT_A = AW'(1) << FRACTION_BITS;

  logic [AW-1:0] acc_q, acc_d;
  logic [FW-1:0] factor_ext, factor_clamped, excess_f;

  assign factor_ext     = FW'(factor_i);
  assign factor_clamped = (factor_ext > TOP_F) ? TOP_F : factor_ext;
  // only used while the factor is above one unit
  assign excess_f       = factor_clamped - UNIT_F;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = acc_q + AW'(excess_f);
    end else if (ctrl_i.sub) begin
      acc_d = acc_q - UNIT_A;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign ge_unit_o = (acc_q >= UNIT_A);

endmodule

// File: design/ipa_vowel_stretcher_unit.sv
// ipa vowel stretcher: top level with byte collection, scan sequencer and output register
//
// Takes a UTF-8 string one byte per word and repeats IPA vowels by the stretch factor
// (1/256 units, clamped to 3.0; 1.0 or less passes bytes unchanged). A byte that only
// completes part of a character returns no word, and the next byte can be taken on the next cycle.
// Otherwise the byte is taken and the sequencer walks the collected bytes: a raw byte is
// emitted as it is, a character is decoded byte by byte in the fold unit, stepped once in
// the accumulator, then emitted byte by byte, a stretched vowel up to two more times.
// A stalled output register holds the sequencer until the word leaves.
// in_ready_o is low while a byte is being worked on; the last output word can still
// wait in the output register while the next byte is taken. Write stretch_factor only
// while the block is idle. run_end_o marks the last word caused by an input byte and
// string_end_o the last word of the string.
module ipa_vowel_stretcher_unit
  import ivs_pkg::*;
#(
  parameter int FRACTION_BITS = IVS_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              stretch_factor_we_i,
  input  logic [CFG_W-1:0]  stretch_factor_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              end_of_input_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              run_end_o,
  output logic              string_end_o
);

  localparam int AW = FRACTION_BITS + 2;
  localparam int FW = (AW > CFG_W) ? AW : CFG_W;
  localparam logic [FW-1:0] UNIT_F = FW'(1) << FRACTION_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECODE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CFG_W-1:0] cfg_q;

  // character collection
  logic [BYTE_W-1:0] pend_q [3];
  logic [BYTE_W-1:0] pend_d [3];
  logic [1:0]        pcnt_q, pcnt_d;
  logic [LEN_W-1:0]  need_q, need_d;

  // work buffer walked by the sequencer
  logic [BYTE_W-1:0] wbuf_q [4];
  logic [BYTE_W-1:0] wbuf_d [4];
  logic [2:0]        n_q, n_d;
  logic [2:0]        ptr_q, ptr_d;
  logic [2:0]        cs_q, cs_d;
  logic [2:0]        cend_q, cend_d;
  logic              raw_q, raw_d;
  logic              last_q, last_d;
  logic              add_q, add_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              run_end_q, run_end_d;
  logic              str_end_q, str_end_d;

  logic              in_fire, stretch_on, collect;
  logic [LEN_W-1:0]  lead_in, cur_len;
  logic [2:0]        pcnt_inc, avail;
  logic [BYTE_W-1:0] cur_byte;
  logic              take_raw, can_emit, at_end, more, vowel, acc_ge;
  acc_ctrl_t         acc_ctrl;
  fold_ctrl_t        fold_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign stretch_on = (FW'(cfg_q) > UNIT_F);
  assign lead_in    = lead_len(data_byte_i);
  assign pcnt_inc   = {1'b0, pcnt_q} + 3'd1;
  assign collect    = stretch_on && (((need_q == '0) && (lead_in >= 3'd2)) ||
                                     ((need_q != '0) && (pcnt_inc < need_q)));

  assign cur_byte = wbuf_q[ptr_q[1:0]];
  assign cur_len  = lead_len(cur_byte);
  assign avail    = n_q - ptr_q;
  assign take_raw = raw_q || (cur_len == '0) || (cur_len > avail);
  assign can_emit = !out_valid_q || out_ready_i;
  assign at_end   = (ptr_q + 3'd1 == cend_q);
  assign more     = at_end && vowel && acc_ge;

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    need_d      = need_q;
    wbuf_d      = wbuf_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    cs_d        = cs_q;
    cend_d      = cend_q;
    raw_d       = raw_q;
    last_d      = last_q;
    add_d       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    str_end_d   = str_end_q;
    acc_ctrl    = '0;
    fold_ctrl   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // held bytes first, the new byte right after them
          for (int k = 0; k < 3; k++) begin
            wbuf_d[k] = (2'(k) < pcnt_q) ? pend_q[k] : data_byte_i;
          end
          wbuf_d[3] = data_byte_i;
          raw_d  = !stretch_on;
          last_d = end_of_input_i;
          ptr_d  = '0;
          n_d    = (collect && !end_of_input_i) ? 3'd0 : pcnt_inc;
          state_d = (collect && !end_of_input_i) ? ST_IDLE : ST_SCAN;

          if (!stretch_on || end_of_input_i) begin
            pcnt_d = '0;
            need_d = '0;
          end else if (need_q == '0) begin
            if (lead_in >= 3'd2) begin
              pend_d[0] = data_byte_i;
              pcnt_d    = 2'd1;
              need_d    = lead_in;
            end else begin
              pcnt_d = '0;
              need_d = '0;
            end
          end else if (pcnt_inc >= need_q) begin
            pcnt_d = '0;
            need_d = '0;
          end else begin
            pend_d[pcnt_q] = data_byte_i;
            pcnt_d         = pcnt_q + 2'd1;
          end
        end
      end

      ST_SCAN: begin
        if (take_raw) begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            out_byte_d  = cur_byte;
            run_end_d   = (ptr_q + 3'd1 == n_q);
            str_end_d   = (ptr_q + 3'd1 == n_q) && last_q;
            ptr_d       = ptr_q + 3'd1;
            if (ptr_q + 3'd1 == n_q) begin
              state_d        = ST_IDLE;
              acc_ctrl.clear = last_q;
            end
          end
        end else begin
          // start of a complete character: lead goes into the fold unit
          fold_ctrl.load = 1'b1;
          cs_d   = ptr_q;
          cend_d = ptr_q + cur_len;
          ptr_d  = ptr_q + 3'd1;
          if (cur_len == 3'd1) begin
            add_d   = 1'b1;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_DECODE;
          end
        end
      end

      ST_DECODE: begin
        fold_ctrl.step = 1'b1;
        ptr_d = ptr_q + 3'd1;
        if (at_end) begin
          add_d   = 1'b1;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (add_q) begin
          // accumulator step, then rewind to the first byte of the character
          acc_ctrl.add = vowel;
          ptr_d        = cs_q;
        end else if (can_emit) begin
          out_valid_d = 1'b1;
          out_byte_d  = cur_byte;
          run_end_d   = at_end && !more && (cend_q == n_q);
          str_end_d   = at_end && !more && (cend_q == n_q) && last_q;
          if (!at_end) begin
            ptr_d = ptr_q + 3'd1;
          end else if (more) begin
            acc_ctrl.sub = 1'b1;
            ptr_d        = cs_q;
          end else if (cend_q == n_q) begin
            state_d        = ST_IDLE;
            acc_ctrl.clear = last_q;
          end else begin
            ptr_d   = cend_q;
            state_d = ST_SCAN;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      pcnt_q      <= '0;
      need_q      <= '0;
      out_valid_q <= 1'b0;
      add_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      pcnt_q      <= pcnt_d;
      need_q      <= need_d;
      out_valid_q <= out_valid_d;
      add_q       <= add_d;
      if (stretch_factor_we_i) begin
        cfg_q <= stretch_factor_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_d_loop: for (int k = 0; k < 3; k++) begin
      pend_q[k] <= pend_d[k];
    end
    wbuf_d_loop: for (int k = 0; k < 4; k++) begin
      wbuf_q[k] <= wbuf_d[k];
    end
    n_q        <= n_d;
    ptr_q      <= ptr_d;
    cs_q       <= cs_d;
    cend_q     <= cend_d;
    raw_q      <= raw_d;
    last_q     <= last_d;
    out_byte_q <= out_byte_d;
    run_end_q  <= run_end_d;
    str_end_q  <= str_end_d;
  end

  ivs_cp_fold u_fold (
    .clk_i   (clk_i),
    .ctrl_i  (fold_ctrl),
    .byte_i  (cur_byte),
    .len_i   (cur_len),
    .vowel_o (vowel)
  );

  ivs_frac_acc #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .factor_i  (cfg_q),
    .ge_unit_o (acc_ge)
  );

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_end_o    = run_end_q;
  assign string_end_o = str_end_q;

endmodule

// File: verif/tb_top.sv
// testbench of the ipa vowel stretcher: random utf-8 strings checked against a built-in predictor
module tb_top;
  import ivs_pkg::*;

  localparam int UNIT      = 1 << IVS_FRACTION_BITS;
  localparam int TOP       = 3 * UNIT;
  localparam int MAX_WORDS = 12;
  localparam int SETTLE    = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_end;
    logic              str_end;
  } out_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              factor_we = 1'b0;
  logic [CFG_W-1:0]  factor_val = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              in_eoi = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              run_end;
  logic              string_end;

  always #6 clk = ~clk;

  ipa_vowel_stretcher_unit i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .stretch_factor_we_i (factor_we),
    .stretch_factor_i    (factor_val),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .data_byte_i         (in_byte),
    .end_of_input_i      (in_eoi),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .out_byte_o          (out_byte),
    .run_end_o           (run_end),
    .string_end_o        (string_end)
  );

  int unsigned latin_vowels [12] = '{'h61, 'h41, 'h65, 'h45, 'h69, 'h49,
                                     'h6F, 'h4F, 'h75, 'h55, 'h79, 'h59};
  int unsigned ipa_vowels [26] = '{'hE6, 'hC6, 'hF8, 'hD8, 'h153, 'h152,
                                   'h250, 'h251, 'h252, 'h254,
                                   'h259, 'h25A, 'h25B, 'h25C, 'h25D, 'h25E,
                                   'h264, 'h268, 'h26A, 'h26F, 'h275, 'h276,
                                   'h289, 'h28A, 'h28C, 'h28F};

  // predictor state
  logic [CFG_W-1:0]       factor_reg = CFG_RESET;
  logic [2:0][BYTE_W-1:0] held_bytes = '0;
  int                     held_cnt = 0;
  int                     want_len = 0;
  int                     frac_acc = 0;

  in_word_t  byte_queue [$];
  out_word_t expected_words [$];
  out_word_t step_words [$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int          err_cnt = 0;
  logic        send_steady = 1'b0;
  logic        recv_steady = 1'b0;

  function automatic int char_len(logic [BYTE_W-1:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  function automatic bit is_vowel(int unsigned cp);
    foreach (latin_vowels[k]) if (latin_vowels[k] == cp) return 1'b1;
    foreach (ipa_vowels[k]) if (ipa_vowels[k] == cp) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void emit_byte(logic [BYTE_W-1:0] b);
    out_word_t w;
    w = '{b, 1'b0, 1'b0};
    if (step_words.size() < MAX_WORDS) step_words.insert(step_words.size(), w);
  endfunction

  // emit a whole character, then one more copy per whole unit of vowel excess
  function automatic void stretch_char(logic [3:0][BYTE_W-1:0] chars, int len, int factor);
    int unsigned cp;
    for (int k = 0; k < len; k++) emit_byte(chars[k]);
    if (len == 1) begin
      cp = 32'(chars[0]);
    end else begin
      cp = (len == 2) ? (chars[0] & 'h1F) : (len == 3) ? (chars[0] & 'h0F) : (chars[0] & 'h07);
      for (int k = 1; k < len; k++) cp = (cp << 6) | (chars[k] & 'h3F);
    end
    if (!is_vowel(cp)) return;
    frac_acc += factor - UNIT;
    while (frac_acc >= UNIT) begin
      for (int k = 0; k < len; k++) emit_byte(chars[k]);
      frac_acc -= UNIT;
    end
  endfunction

  function automatic void predict_words(logic [BYTE_W-1:0] b, logic last);
    int factor;
    int len;
    int i;
    logic [3:0][BYTE_W-1:0] chars;
    out_word_t w;
    factor = (int'(factor_reg) > TOP) ? TOP : int'(factor_reg);
    step_words.delete();
    chars = '0;
    if (factor <= UNIT) begin
      for (int k = 0; k < held_cnt; k++) emit_byte(held_bytes[k]);
      held_cnt = 0;
      want_len = 0;
      emit_byte(b);
    end else if (want_len == 0 || held_cnt == 0) begin
      len = char_len(b);
      want_len = 0;
      held_cnt = 0;
      if (len == 0) begin
        emit_byte(b);
      end else if (len == 1) begin
        chars[0] = b;
        stretch_char(chars, 1, factor);
      end else begin
        held_bytes[0] = b;
        held_cnt = 1;
        want_len = len;
      end
    end else if (held_cnt + 1 >= want_len) begin
      for (int k = 0; k < held_cnt; k++) chars[k] = held_bytes[k];
      chars[held_cnt] = b;
      len = held_cnt + 1;
      held_cnt = 0;
      want_len = 0;
      stretch_char(chars, len, factor);
    end else begin
      held_bytes[held_cnt] = b;
      held_cnt++;
    end
    if (last) begin
      // string ends inside a character: walk the held bytes again
      i = 0;
      while (i < held_cnt) begin
        len = char_len(held_bytes[i]);
        if (len == 0 || len > held_cnt - i) begin
          emit_byte(held_bytes[i]);
          i++;
        end else begin
          chars = '0;
          for (int k = 0; k < len; k++) chars[k] = held_bytes[i + k];
          stretch_char(chars, len, factor);
          i += len;
        end
      end
      held_cnt = 0;
      want_len = 0;
      frac_acc = 0;
    end
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.run_end = 1'b1;
      w.str_end = last;
      step_words.insert(step_words.size(), w);
    end
    foreach (step_words[k]) expected_words.insert(expected_words.size(), step_words[k]);
  endfunction

  function automatic int idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // stimulus helpers
  function automatic void queue_byte(logic [BYTE_W-1:0] b, logic last);
    in_word_t w;
    w = '{b, last};
    byte_queue.insert(byte_queue.size(), w);
    bytes_queued++;
  endfunction

  function automatic void queue_point(int unsigned cp, logic last);
    if (cp < 'h80) begin
      queue_byte(cp[7:0], last);
    end else if (cp < 'h800) begin
      queue_byte(8'hC0 | cp[10:6], 1'b0);
      queue_byte(8'h80 | cp[5:0], last);
    end else if (cp < 'h10000) begin
      queue_byte(8'hE0 | cp[15:12], 1'b0);
      queue_byte(8'h80 | cp[11:6], 1'b0);
      queue_byte(8'h80 | cp[5:0], last);
    end else begin
      queue_byte(8'hF0 | cp[20:18], 1'b0);
      queue_byte(8'h80 | cp[17:12], 1'b0);
      queue_byte(8'h80 | cp[11:6], 1'b0);
      queue_byte(8'h80 | cp[5:0], last);
    end
  endfunction

  // a lead followed by too few bytes; the followers are arbitrary
  function automatic void queue_partial(logic last);
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] fill;
    int unsigned pick;
    int nfollow;
    pick = $urandom_range(0, 2);
    if (pick == 0) lead = 8'($urandom_range('hC0, 'hDF));
    else if (pick == 1) lead = 8'($urandom_range('hE0, 'hEF));
    else lead = 8'($urandom_range('hF0, 'hF7));
    nfollow = $urandom_range(0, char_len(lead) - 2);
    queue_byte(lead, last && nfollow == 0);
    for (int k = 0; k < nfollow; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) fill = 8'($urandom_range('h80, 'hBF));
      else if (pick < 70) fill = 8'(latin_vowels[$urandom_range(0, 11)]);
      else if (pick < 85) fill = ($urandom_range(0, 1) != 0) ? 8'hC3 : 8'hC9;
      else fill = 8'($urandom_range(0, 255));
      queue_byte(fill, last && k == nfollow - 1);
    end
  endfunction

  function automatic void queue_token(logic last);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) queue_point(latin_vowels[$urandom_range(0, 11)], last);
    else if (pick < 45) queue_point(ipa_vowels[$urandom_range(0, 25)], last);
    else if (pick < 63) queue_point($urandom_range(0, 'h7F), last);
    else if (pick < 73) queue_point($urandom_range('h80, 'h7FF), last);
    else if (pick < 80) queue_point($urandom_range('h800, 'hFFFF), last);
    else if (pick < 85) queue_point($urandom_range('h10000, 'h1FFFFF), last);
    else if (pick < 94) queue_byte(8'($urandom_range(0, 255)), last);
    else queue_partial(last);
  endfunction

  task automatic write_factor(logic [CFG_W-1:0] v);
    @(posedge clk);
    factor_we  <= 1'b1;
    factor_val <= v;
    @(posedge clk);
    factor_we  <= 1'b0;
    factor_reg = v;
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || expected_words.size() != 0) @(posedge clk);
    // a byte that only gets collected gives no word, so let the block settle
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] factor, int unsigned target);
    int unsigned start;
    int unsigned nchars;
    int unsigned pick;
    write_factor(factor);
    send_steady <= ($urandom_range(0, 3) == 0);
    recv_steady <= ($urandom_range(0, 3) == 0);
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      nchars = $urandom_range(1, 6);
      pick = $urandom_range(0, 99);
      for (int k = 0; k < nchars; k++) queue_token(k == nchars - 1 && pick >= 20);
      if (pick < 20) queue_partial(1'b1);
    end
    // sometimes keep a character open across the next factor change
    if ($urandom_range(0, 2) == 0) queue_partial(1'b0);
    wait_idle();
  endtask

  // input driver
  logic     send_now;
  int       gap_left = 0;
  in_word_t next_item;

  always @(posedge clk) begin
    if (rst_n) begin
      send_now = in_valid;
      if (in_valid && in_ready) begin
        predict_words(in_byte, in_eoi);
        bytes_taken++;
        send_now = 1'b0;
      end
      if (!send_now) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_queue.size() != 0) begin
          next_item = byte_queue.pop_front();
          in_byte  <= next_item.data;
          in_eoi   <= next_item.last;
          send_now = 1'b1;
          gap_left = send_steady ? 0 : idle_len();
        end
      end
      in_valid <= send_now;
    end
  end

  // output monitor
  int        stall_left = 0;
  out_word_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte %02h", out_byte);
          err_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            err_cnt++;
          end
          if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, run_end);
            err_cnt++;
          end
          if (string_end !== want.str_end) begin
            $error("string_end: expected %0b, got %0b", want.str_end, string_end);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_steady && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: factor clamped to 3.0
    write_factor(10'd1023);
    queue_byte(8'h61, 1'b1);
    queue_byte(8'hC9, 1'b0);
    queue_byte(8'h99, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // over-long lead
    queue_byte(8'hC0, 1'b0);
    queue_byte(8'h80, 1'b1);
    // code point beyond unicode
    queue_byte(8'hF4, 1'b0);
    queue_byte(8'h90, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b1);
    // string ends inside a character, vowels hidden in the held bytes
    queue_byte(8'hE0, 1'b0);
    queue_byte(8'h61, 1'b1);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'hA6, 1'b1);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h7F, 1'b1);
    // lead left open, flushed raw once the factor drops to 1.0
    queue_byte(8'hC9, 1'b0);
    wait_idle();
    write_factor(CFG_RESET);
    queue_byte(8'h41, 1'b1);
    wait_idle();

    run_phase(10'd0, 9);
    run_phase(10'd768, 9);
    run_phase(10'd257, 9);
    run_phase(10'd384, 9);
    run_phase(10'd1023, 9);
    run_phase(CFG_W'($urandom_range(258, 767)), 9);
    run_phase(10'd256, 9);
    run_phase(10'd900, 9);
    run_phase(10'd512, 9);

    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
